@@ src/kgc_pkg.sv @@
// Package for the Kalman gain compute unit: sizes, sequencer states, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kgc_pkg;
	localparam int NUM_STATES_DEF = 7;
	localparam int NUM_MEAS_DEF = 9;
	localparam int VAL_W = 32;
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

	typedef enum logic [1:0] {
		MODE_LOAD_H = 2'd0,
		MODE_LOAD_P = 2'd1,
		MODE_LOAD_R = 2'd2,
		MODE_COMPUTE = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_HP_RD,   // issue reads for one H*P term
		ST_HP_ACC,
		ST_HP_WR,
		ST_S_RD,
		ST_S_ACC,
		ST_S_WR,
		ST_INV_INIT,
		ST_PIV_RD,
		ST_PIV_CMP,
		ST_PIV_CHK,
		ST_SWP_RD,
		ST_SWP_WR,
		ST_NRM_RD,
		ST_NRM_DIV,
		ST_NRM_WR,
		ST_ELM_RDF,
		ST_ELM_F,
		ST_ELM_RD,
		ST_ELM_WR,
		ST_T_RD,
		ST_T_ACC,
		ST_T_WR,
		ST_K_RD,
		ST_K_ACC,
		ST_K_OUT,
		ST_K_WAIT
	} state_t;

	// Saturate a 64-bit value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

@@ src/kgc_stream_if.sv @@
// Valid/ready channel interface for the Kalman gain unit.
// Payload type is a parameter; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
interface kgc_stream_if #(parameter type payload_t = logic) (input wire logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/kgc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kgc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ src/kgc_divider.sv @@
// Restoring divider: signed (a*65536)/b truncated toward zero, saturated.
// Depends on kgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kgc_divider (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [31:0] num,
	input wire logic signed [31:0] den,
	output logic done,
	output logic signed [31:0] quo
);
	logic [47:0] n_q;
	logic [31:0] d_q;
	logic [48:0] rem_q;
	logic [47:0] qb_q;
	logic [5:0] cnt_q;
	logic neg_q;
	logic busy_q;
	logic [48:0] trial;
	logic signed [63:0] sres;

	assign trial = {rem_q[47:0], n_q[47]} - {17'd0, d_q};
	assign sres = neg_q ? -$signed({16'd0, qb_q}) : $signed({16'd0, qb_q});

	// One quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
			d_q <= den[31] ? 32'(-den) : 32'(den);
			neg_q <= num[31] ^ den[31];
			rem_q <= '0;
			qb_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[46:0], 1'b0};
			if (!trial[48]) begin
				rem_q <= trial;
				qb_q <= {qb_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[47:0], n_q[47]};
				qb_q <= {qb_q[46:0], 1'b0};
			end
		end
	end

	assign quo = kgc_pkg::sat32(sres);
endmodule
`default_nettype wire

@@ src/kgc_mac.sv @@
// Shared multiply unit: 32x32 product, floor shift by 16, registered.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kgc_mac (
	input wire logic clk,
	input wire logic signed [31:0] a,
	input wire logic signed [31:0] b,
	output logic signed [47:0] prod_s1
);
	logic signed [63:0] p;
	assign p = 64'(a) * 64'(b);
	// Arithmetic shift is floor division by 65536.
	always_ff @(posedge clk) prod_s1 <= 48'(p >>> 16);
endmodule
`default_nettype wire

@@ src/kalman_gain_compute_unit.sv @@
// Top level of the Kalman gain compute unit.
// Depends on kgc_pkg, kgc_stream_if, kgc_ram, kgc_mac, kgc_divider.
//
// Input channel (sink): mode/row/col/value. Modes 0..2 write one entry of H,
// P or R; out-of-range indexes are dropped. Mode 3 starts a run.
// During a run the block is not ready. The run computes H*P, S = HPH^T + R,
// inverts S by Gauss-Jordan with partial pivoting on one shared multiplier
// and one bit-serial divider, then T = H^T S^-1 and K = P T.
// The run covers the products and the result hand-off, the identity load and,
// per pivot column c, the search, a row swap when one is needed, the row
// scaling (one divide per entry) and the elimination; its length is set
// mostly by the serial divider and the single multiply port.
// Output channel (source): 63 gain entries row-major; last flags the final
// one, singular flags every entry when a zero pivot was found (values zero).
// A result is held in the output register while the receiver stalls.
// Reset clears the sequencer and the output valid; stored matrices stay
// undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module kalman_gain_compute_unit #(
	parameter int NUM_STATES = kgc_pkg::NUM_STATES_DEF,
	parameter int NUM_MEAS = kgc_pkg::NUM_MEAS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	kgc_stream_if.sink in_ch,
	kgc_stream_if.source out_ch
);
	localparam int N = NUM_STATES;
	localparam int M = NUM_MEAS;
	localparam int IW = 4;
	localparam int HD = M * N;
	localparam int PD = N * N;
	localparam int SD = M * M;
	localparam int HA = $clog2(HD);
	localparam int PA = $clog2(PD);
	localparam int SA = $clog2(SD);

	kgc_pkg::state_t st_q, st_d;

	logic [IW-1:0] i_q, j_q, k_q, c_q, piv_q;
	logic [IW-1:0] i_d, j_d, k_d, c_d, piv_d;
	logic signed [51:0] acc_q, acc_d;
	logic signed [31:0] f_q, f_d, pv_q, pv_d, tmp_a_q, tmp_a_d, tmp_b_q, tmp_b_d;
	logic [32:0] best_q, best_d;
	logic sing_q, sing_d, inv_q, inv_d;

	// Memory ports
	logic h_we, p_we, r_we, w_we, s_we, v_we, t_we;
	logic [HA-1:0] h_wa, h_ra, w_wa, w_ra, t_wa, t_ra;
	logic [PA-1:0] p_wa, p_ra;
	logic [SA-1:0] r_wa, r_ra, s_wa, s_ra, v_wa, v_ra;
	logic [31:0] h_wd, p_wd, r_wd, w_wd, s_wd, v_wd, t_wd;
	logic [31:0] h_rd, p_rd, r_rd, w_rd, s_rd, v_rd, t_rd;

	kgc_ram #(.WIDTH(32), .DEPTH(HD)) u_h (.clk, .we(h_we), .waddr(h_wa), .wdata(h_wd),
		.raddr(h_ra), .rdata(h_rd));
	kgc_ram #(.WIDTH(32), .DEPTH(PD)) u_p (.clk, .we(p_we), .waddr(p_wa), .wdata(p_wd),
		.raddr(p_ra), .rdata(p_rd));
	kgc_ram #(.WIDTH(32), .DEPTH(SD)) u_r (.clk, .we(r_we), .waddr(r_wa), .wdata(r_wd),
		.raddr(r_ra), .rdata(r_rd));
	kgc_ram #(.WIDTH(32), .DEPTH(HD)) u_hp (.clk, .we(w_we), .waddr(w_wa), .wdata(w_wd),
		.raddr(w_ra), .rdata(w_rd));
	kgc_ram #(.WIDTH(32), .DEPTH(SD)) u_s (.clk, .we(s_we), .waddr(s_wa), .wdata(s_wd),
		.raddr(s_ra), .rdata(s_rd));
	kgc_ram #(.WIDTH(32), .DEPTH(SD)) u_v (.clk, .we(v_we), .waddr(v_wa), .wdata(v_wd),
		.raddr(v_ra), .rdata(v_rd));
	kgc_ram #(.WIDTH(32), .DEPTH(HD)) u_t (.clk, .we(t_we), .waddr(t_wa), .wdata(t_wd),
		.raddr(t_ra), .rdata(t_rd));

	// Shared multiplier and divider
	logic signed [31:0] mul_a, mul_b;
	logic signed [47:0] prod_s1;
	kgc_mac u_mac (.clk, .a(mul_a), .b(mul_b), .prod_s1);

	logic div_start, div_done;
	logic signed [31:0] div_num, div_den, div_quo;
	kgc_divider u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo));

	// Output register
	logic ov_q, ov_d;
	logic [2:0] orow_q, orow_d;
	logic [3:0] ocol_q, ocol_d;
	logic [31:0] oval_q, oval_d;
	logic olast_q, olast_d, osing_q, osing_d;

	assign out_ch.valid = ov_q;
	assign out_ch.data.gain_row = orow_q;
	assign out_ch.data.gain_col = ocol_q;
	assign out_ch.data.gain_value = oval_q;
	assign out_ch.data.last = olast_q;
	assign out_ch.data.singular = osing_q;
	assign in_ch.ready = (st_q == kgc_pkg::ST_IDLE);

	function automatic logic [SA-1:0] sidx(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return SA'(r * M + c);
	endfunction
	function automatic logic [HA-1:0] hidx(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return HA'(r * N + c);
	endfunction
	function automatic logic [HA-1:0] tidx(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return HA'(r * M + c);
	endfunction
	function automatic logic [PA-1:0] pidx(input logic [IW-1:0] r, input logic [IW-1:0] c);
		return PA'(r * N + c);
	endfunction
	function automatic logic [32:0] mag(input logic [31:0] v);
		return v[31] ? 33'(-$signed({v[31], v})) : {1'b0, v};
	endfunction

	logic signed [31:0] acc_sat;
	assign acc_sat = kgc_pkg::sat32(64'(acc_q));

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= kgc_pkg::ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d; j_q <= j_d; k_q <= k_d; c_q <= c_d; piv_q <= piv_d;
		acc_q <= acc_d; f_q <= f_d; pv_q <= pv_d; best_q <= best_d;
		tmp_a_q <= tmp_a_d; tmp_b_q <= tmp_b_d;
		sing_q <= sing_d; inv_q <= inv_d;
		orow_q <= orow_d; ocol_q <= ocol_d; oval_q <= oval_d;
		olast_q <= olast_d; osing_q <= osing_d;
	end

	// Next state, memory control and datapath selection
	always_comb begin
		logic signed [63:0] sub_s, sub_v;
		st_d = st_q;
		i_d = i_q; j_d = j_q; k_d = k_q; c_d = c_q; piv_d = piv_q;
		acc_d = acc_q; f_d = f_q; pv_d = pv_q; best_d = best_q;
		tmp_a_d = tmp_a_q; tmp_b_d = tmp_b_q;
		sing_d = sing_q; inv_d = inv_q;
		ov_d = ov_q; orow_d = orow_q; ocol_d = ocol_q; oval_d = oval_q;
		olast_d = olast_q; osing_d = osing_q;
		h_we = 1'b0; p_we = 1'b0; r_we = 1'b0; w_we = 1'b0;
		s_we = 1'b0; v_we = 1'b0; t_we = 1'b0;
		h_wa = hidx(in_ch.data.row, in_ch.data.col);
		p_wa = pidx(in_ch.data.row, in_ch.data.col);
		r_wa = sidx(in_ch.data.row, in_ch.data.col);
		h_wd = in_ch.data.value; p_wd = in_ch.data.value; r_wd = in_ch.data.value;
		h_ra = '0; p_ra = '0; r_ra = '0; w_ra = '0; s_ra = '0; v_ra = '0; t_ra = '0;
		w_wa = hidx(i_q, j_q); w_wd = acc_sat;
		s_wa = sidx(i_q, j_q); s_wd = acc_sat;
		v_wa = sidx(i_q, j_q); v_wd = acc_sat;
		t_wa = tidx(i_q, j_q); t_wd = acc_sat;
		mul_a = '0; mul_b = '0;
		div_start = 1'b0; div_num = tmp_a_q; div_den = pv_q;
		sub_s = '0; sub_v = '0;
		if (ov_q && out_ch.ready) ov_d = 1'b0;

		unique case (st_q)
			kgc_pkg::ST_IDLE: begin
				i_d = '0; j_d = '0; k_d = '0; acc_d = '0;
				if (in_ch.valid) begin
					unique case (kgc_pkg::mode_t'(in_ch.data.mode))
						kgc_pkg::MODE_LOAD_H:
							h_we = (in_ch.data.row < M) && (in_ch.data.col < N);
						kgc_pkg::MODE_LOAD_P:
							p_we = (in_ch.data.row < N) && (in_ch.data.col < N);
						kgc_pkg::MODE_LOAD_R:
							r_we = (in_ch.data.row < M) && (in_ch.data.col < M);
						kgc_pkg::MODE_COMPUTE: st_d = kgc_pkg::ST_HP_RD;
						default: ;
					endcase
				end
			end
			// HP[i][j] = sum_k H[i][k]*P[k][j]
			kgc_pkg::ST_HP_RD: begin
				h_ra = hidx(i_q, k_q); p_ra = pidx(k_q, j_q);
				st_d = kgc_pkg::ST_HP_ACC;
			end
			kgc_pkg::ST_HP_ACC: begin
				mul_a = h_rd; mul_b = p_rd;
				st_d = kgc_pkg::ST_HP_WR;
			end
			kgc_pkg::ST_HP_WR: begin
				acc_d = acc_q + prod_s1;
				if (k_q == IW'(N - 1)) begin
					w_we = 1'b1; w_wd = kgc_pkg::sat32(64'(acc_q + prod_s1));
					acc_d = '0; k_d = '0;
					if (j_q == IW'(N - 1)) begin
						j_d = '0;
						if (i_q == IW'(M - 1)) begin i_d = '0; st_d = kgc_pkg::ST_S_RD; end
						else begin i_d = i_q + 1'b1; st_d = kgc_pkg::ST_HP_RD; end
					end else begin j_d = j_q + 1'b1; st_d = kgc_pkg::ST_HP_RD; end
				end else begin k_d = k_q + 1'b1; st_d = kgc_pkg::ST_HP_RD; end
			end
			// S[i][j] = sum_k HP[i][k]*H[j][k] + R[i][j]
			kgc_pkg::ST_S_RD: begin
				w_ra = hidx(i_q, k_q); h_ra = hidx(j_q, k_q); r_ra = sidx(i_q, j_q);
				st_d = kgc_pkg::ST_S_ACC;
			end
			kgc_pkg::ST_S_ACC: begin
				mul_a = w_rd; mul_b = h_rd; tmp_b_d = r_rd;
				st_d = kgc_pkg::ST_S_WR;
			end
			kgc_pkg::ST_S_WR: begin
				acc_d = acc_q + prod_s1;
				if (k_q == IW'(N - 1)) begin
					s_we = 1'b1;
					s_wd = kgc_pkg::sat32(64'(kgc_pkg::sat32(64'(acc_q + prod_s1)))
						+ 64'(tmp_b_q));
					acc_d = '0; k_d = '0;
					if (j_q == IW'(M - 1)) begin
						j_d = '0;
						if (i_q == IW'(M - 1)) begin i_d = '0; st_d = kgc_pkg::ST_INV_INIT; end
						else begin i_d = i_q + 1'b1; st_d = kgc_pkg::ST_S_RD; end
					end else begin j_d = j_q + 1'b1; st_d = kgc_pkg::ST_S_RD; end
				end else begin k_d = k_q + 1'b1; st_d = kgc_pkg::ST_S_RD; end
			end
			// Load the identity into the inverse store.
			kgc_pkg::ST_INV_INIT: begin
				v_we = 1'b1; v_wd = (i_q == j_q) ? kgc_pkg::ONE_Q16 : '0;
				sing_d = 1'b0; c_d = '0;
				if (j_q == IW'(M - 1)) begin
					j_d = '0;
					if (i_q == IW'(M - 1)) begin
						i_d = '0; st_d = kgc_pkg::ST_PIV_RD;
					end else i_d = i_q + 1'b1;
				end else j_d = j_q + 1'b1;
			end
			// Pivot search over rows c..M-1
			kgc_pkg::ST_PIV_RD: begin
				if (i_q == '0) begin i_d = c_q; piv_d = c_q; best_d = '0; end
				s_ra = sidx((i_q == '0) ? c_q : i_q, c_q);
				st_d = kgc_pkg::ST_PIV_CMP;
			end
			kgc_pkg::ST_PIV_CMP: begin
				if (i_q == c_q || mag(s_rd) > best_q) begin
					best_d = mag(s_rd); piv_d = i_q; tmp_a_d = s_rd;
				end
				if (i_q == IW'(M - 1)) st_d = kgc_pkg::ST_PIV_CHK;
				else begin i_d = i_q + 1'b1; st_d = kgc_pkg::ST_PIV_RD; end
			end
			kgc_pkg::ST_PIV_CHK: begin
				j_d = '0; inv_d = 1'b0;
				pv_d = tmp_a_q;
				if (tmp_a_q == '0) begin
					sing_d = 1'b1; i_d = '0; j_d = '0; st_d = kgc_pkg::ST_K_RD;
				end else if (piv_q != c_q) st_d = kgc_pkg::ST_SWP_RD;
				else st_d = kgc_pkg::ST_NRM_RD;
			end
			// Swap rows c and piv in both stores, one column per pass.
			kgc_pkg::ST_SWP_RD: begin
				if (!inv_q) begin s_ra = sidx(c_q, j_q); v_ra = sidx(piv_q, j_q); end
				else begin s_ra = sidx(piv_q, j_q); v_ra = sidx(c_q, j_q); end
				st_d = kgc_pkg::ST_SWP_WR;
			end
			kgc_pkg::ST_SWP_WR: begin
				if (!inv_q) begin
					tmp_a_d = s_rd; tmp_b_d = v_rd; inv_d = 1'b1; st_d = kgc_pkg::ST_SWP_RD;
				end else begin
					// s_rd = S[piv], v_rd = V[c]; tmp_a = S[c], tmp_b = V[piv]
					s_we = 1'b1; s_wa = sidx(c_q, j_q); s_wd = s_rd;
					v_we = 1'b1; v_wa = sidx(piv_q, j_q); v_wd = v_rd;
					f_d = tmp_b_q; inv_d = 1'b0;
					st_d = kgc_pkg::ST_ELM_WR;
					i_d = '1;
				end
			end
			// Scale row c by 1/pivot: S then V, one divide each.
			kgc_pkg::ST_NRM_RD: begin
				if (!inv_q) s_ra = sidx(c_q, j_q); else v_ra = sidx(c_q, j_q);
				st_d = kgc_pkg::ST_NRM_DIV;
			end
			kgc_pkg::ST_NRM_DIV: begin
				div_start = 1'b1; div_num = inv_q ? v_rd : s_rd;
				st_d = kgc_pkg::ST_NRM_WR;
			end
			kgc_pkg::ST_NRM_WR: begin
				if (div_done) begin
					if (!inv_q) begin
						s_we = 1'b1; s_wa = sidx(c_q, j_q); s_wd = div_quo;
						inv_d = 1'b1; st_d = kgc_pkg::ST_NRM_RD;
					end else begin
						v_we = 1'b1; v_wa = sidx(c_q, j_q); v_wd = div_quo;
						inv_d = 1'b0;
						if (j_q == IW'(M - 1)) begin
							j_d = '0; i_d = '0; st_d = kgc_pkg::ST_ELM_RDF;
						end else begin j_d = j_q + 1'b1; st_d = kgc_pkg::ST_NRM_RD; end
					end
				end
			end
			// Eliminate column c from every other row i.
			kgc_pkg::ST_ELM_RDF: begin
				if (i_q == c_q) begin
					if (i_q == IW'(M - 1)) begin
						i_d = '0;
						if (c_q == IW'(M - 1)) begin c_d = '0; st_d = kgc_pkg::ST_T_RD; end
						else begin c_d = c_q + 1'b1; st_d = kgc_pkg::ST_PIV_RD; end
					end else i_d = i_q + 1'b1;
				end else begin
					s_ra = sidx(i_q, c_q); j_d = '0; st_d = kgc_pkg::ST_ELM_F;
				end
			end
			kgc_pkg::ST_ELM_F: begin
				f_d = s_rd;
				s_ra = sidx(c_q, j_q); v_ra = sidx(c_q, j_q);
				st_d = kgc_pkg::ST_ELM_RD;
			end
			kgc_pkg::ST_ELM_RD: begin
				// Row c entries in hand; multiply S side first.
				tmp_a_d = s_rd; tmp_b_d = v_rd;
				mul_a = f_q; mul_b = s_rd;
				s_ra = sidx(i_q, j_q); v_ra = sidx(i_q, j_q);
				inv_d = 1'b0;
				st_d = kgc_pkg::ST_ELM_WR;
			end
			kgc_pkg::ST_ELM_WR: begin
				if (i_q == '1) begin
					// Return from the swap: next swap column or normalize.
					i_d = '0;
					if (j_q == IW'(M - 1)) begin j_d = '0; st_d = kgc_pkg::ST_NRM_RD; end
					else begin j_d = j_q + 1'b1; st_d = kgc_pkg::ST_SWP_RD; end
					s_we = 1'b1; s_wa = sidx(piv_q, j_q); s_wd = tmp_a_q;
					v_we = 1'b1; v_wa = sidx(c_q, j_q); v_wd = f_q;
				end else if (!inv_q) begin
					sub_s = 64'($signed(s_rd)) - 64'(kgc_pkg::sat32(64'(prod_s1)));
					s_we = 1'b1; s_wa = sidx(i_q, j_q); s_wd = kgc_pkg::sat32(sub_s);
					tmp_a_d = v_rd;
					mul_a = f_q; mul_b = tmp_b_q;
					inv_d = 1'b1;
				end else begin
					sub_v = 64'($signed(tmp_a_q)) - 64'(kgc_pkg::sat32(64'(prod_s1)));
					v_we = 1'b1; v_wa = sidx(i_q, j_q); v_wd = kgc_pkg::sat32(sub_v);
					inv_d = 1'b0;
					if (j_q == IW'(M - 1)) begin
						j_d = '0;
						if (i_q == IW'(M - 1)) begin
							i_d = '0;
							if (c_q == IW'(M - 1)) begin c_d = '0; st_d = kgc_pkg::ST_T_RD; end
							else begin c_d = c_q + 1'b1; st_d = kgc_pkg::ST_PIV_RD; end
						end else begin i_d = i_q + 1'b1; st_d = kgc_pkg::ST_ELM_RDF; end
					end else begin
						j_d = j_q + 1'b1;
						s_ra = sidx(c_q, j_q + 1'b1); v_ra = sidx(c_q, j_q + 1'b1);
						st_d = kgc_pkg::ST_ELM_RD;
					end
				end
			end
			// T[i][j] = sum_k H[k][i]*V[k][j]
			kgc_pkg::ST_T_RD: begin
				h_ra = hidx(k_q, i_q); v_ra = sidx(k_q, j_q);
				st_d = kgc_pkg::ST_T_ACC;
			end
			kgc_pkg::ST_T_ACC: begin
				mul_a = h_rd; mul_b = v_rd;
				st_d = kgc_pkg::ST_T_WR;
			end
			kgc_pkg::ST_T_WR: begin
				acc_d = acc_q + prod_s1;
				if (k_q == IW'(M - 1)) begin
					t_we = 1'b1; t_wd = kgc_pkg::sat32(64'(acc_q + prod_s1));
					acc_d = '0; k_d = '0;
					if (j_q == IW'(M - 1)) begin
						j_d = '0;
						if (i_q == IW'(N - 1)) begin i_d = '0; st_d = kgc_pkg::ST_K_RD; end
						else begin i_d = i_q + 1'b1; st_d = kgc_pkg::ST_T_RD; end
					end else begin j_d = j_q + 1'b1; st_d = kgc_pkg::ST_T_RD; end
				end else begin k_d = k_q + 1'b1; st_d = kgc_pkg::ST_T_RD; end
			end
			// K[i][j] = sum_k P[i][k]*T[k][j]
			kgc_pkg::ST_K_RD: begin
				p_ra = pidx(i_q, k_q); t_ra = tidx(k_q, j_q);
				st_d = sing_q ? kgc_pkg::ST_K_OUT : kgc_pkg::ST_K_ACC;
				if (sing_q) acc_d = '0;
			end
			kgc_pkg::ST_K_ACC: begin
				mul_a = p_rd; mul_b = t_rd;
				st_d = kgc_pkg::ST_K_WAIT;
			end
			kgc_pkg::ST_K_WAIT: begin
				acc_d = acc_q + prod_s1;
				if (k_q == IW'(N - 1)) begin k_d = '0; st_d = kgc_pkg::ST_K_OUT; end
				else begin k_d = k_q + 1'b1; st_d = kgc_pkg::ST_K_RD; end
			end
			kgc_pkg::ST_K_OUT: begin
				if (!ov_q || out_ch.ready) begin
					ov_d = 1'b1;
					orow_d = 3'(i_q); ocol_d = j_q;
					oval_d = sing_q ? '0 : acc_sat;
					osing_d = sing_q;
					olast_d = (i_q == IW'(N - 1)) && (j_q == IW'(M - 1));
					acc_d = '0;
					if (j_q == IW'(M - 1)) begin
						j_d = '0;
						if (i_q == IW'(N - 1)) begin i_d = '0; st_d = kgc_pkg::ST_IDLE; end
						else begin i_d = i_q + 1'b1; st_d = kgc_pkg::ST_K_RD; end
					end else begin j_d = j_q + 1'b1; st_d = kgc_pkg::ST_K_RD; end
				end
			end
			default: st_d = kgc_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

@@ src/kgc_checker.sv @@
// Port-level checker for the Kalman gain compute unit, bound to the top.
// Depends on kgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kgc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [1:0] in_mode,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_last,
	input wire logic out_singular,
	input wire logic [31:0] out_value
);
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(out_last) && $stable(out_singular))
		else $error("stalled result changed");
	// A compute transaction drops ready.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_mode == kgc_pkg::MODE_COMPUTE |=> !in_ready)
		else $error("ready after compute");
	// No result appears while idle with nothing pending.
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !out_valid |=> !out_valid)
		else $error("result while idle");
	// Singular results carry zero.
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_singular |-> out_value == 32'd0)
		else $error("singular result nonzero");
endmodule

bind kalman_gain_compute_unit kgc_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.data.mode),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_last(out_ch.data.last), .out_singular(out_ch.data.singular),
	.out_value(out_ch.data.gain_value)
);
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for kalman_gain_compute_unit: loads H, P and R, runs gain computations
// and checks every gain entry against a bit-exact in-bench model of the EKF gain.
// Depends on kgc_pkg, kgc_stream_if and the RTL of the unit.
`timescale 1ns / 1ps
module tb_top;
	localparam int NS = kgc_pkg::NUM_STATES_DEF;
	localparam int NM = kgc_pkg::NUM_MEAS_DEF;
	localparam int TIMEOUT_CYCLES = 3000000;

	typedef struct packed {
		kgc_pkg::mode_t mode;
		logic [3:0] row;
		logic [3:0] col;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [2:0] gain_row;
		logic [3:0] gain_col;
		logic signed [31:0] gain_value;
		logic last;
		logic singular;
	} gain_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kgc_stream_if #(.payload_t(in_item_t)) in_if (clk);
	kgc_stream_if #(.payload_t(gain_item_t)) out_if (clk);

	kalman_gain_compute_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_if),
		.out_ch(out_if)
	);

	// Model copy of the stored matrices
	int jac[NM][NS];
	int cov[NS][NS];
	int noise[NM][NM];

	in_item_t pending_items[$];
	gain_item_t gain_expected[$];
	int errors = 0;
	int accepted = 0;
	int total_items = 0;
	longint cycles = 0;

	// Clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int sat32_q(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic longint floor16(longint p);
		return p >>> 16;
	endfunction

	function automatic int qmul(int a, int b);
		return sat32_q(floor16(longint'(a) * longint'(b)));
	endfunction

	function automatic int qdiv(int a, int b);
		return sat32_q((longint'(a) * 65536) / longint'(b));
	endfunction

	function automatic longint magn(int a);
		return (a < 0) ? -longint'(a) : longint'(a);
	endfunction

	// Form K = P H^T (H P H^T + R)^-1 and queue the 63 expected gain entries
	task automatic predict_gain();
		int hp[NM][NS];
		int s[NM][NM];
		int inv[NM][NM];
		int tm[NS][NM];
		int piv, pv, f, t;
		longint acc;
		bit ok;
		gain_item_t g;
		for (int i = 0; i < NM; i++)
			for (int j = 0; j < NS; j++) begin
				acc = 0;
				for (int k = 0; k < NS; k++)
					acc += floor16(longint'(jac[i][k]) * longint'(cov[k][j]));
				hp[i][j] = sat32_q(acc);
			end
		for (int i = 0; i < NM; i++)
			for (int j = 0; j < NM; j++) begin
				acc = 0;
				for (int k = 0; k < NS; k++)
					acc += floor16(longint'(hp[i][k]) * longint'(jac[j][k]));
				s[i][j] = sat32_q(longint'(sat32_q(acc)) + longint'(noise[i][j]));
				inv[i][j] = (i == j) ? 65536 : 0;
			end
		// Gauss-Jordan with partial pivoting
		ok = 1'b1;
		for (int c = 0; c < NM && ok; c++) begin
			piv = c;
			for (int r = c + 1; r < NM; r++)
				if (magn(s[r][c]) > magn(s[piv][c])) piv = r;
			if (s[piv][c] == 0) begin
				ok = 1'b0;
			end else begin
				if (piv != c) begin
					for (int j = 0; j < NM; j++) begin
						t = s[c][j]; s[c][j] = s[piv][j]; s[piv][j] = t;
						t = inv[c][j]; inv[c][j] = inv[piv][j]; inv[piv][j] = t;
					end
				end
				pv = s[c][c];
				for (int j = 0; j < NM; j++) begin
					s[c][j] = qdiv(s[c][j], pv);
					inv[c][j] = qdiv(inv[c][j], pv);
				end
				for (int r = 0; r < NM; r++) begin
					if (r != c) begin
						f = s[r][c];
						for (int j = 0; j < NM; j++) begin
							s[r][j] = sat32_q(longint'(s[r][j]) - qmul(f, s[c][j]));
							inv[r][j] = sat32_q(longint'(inv[r][j]) - qmul(f, inv[c][j]));
						end
					end
				end
			end
		end
		if (ok)
			for (int i = 0; i < NS; i++)
				for (int j = 0; j < NM; j++) begin
					acc = 0;
					for (int k = 0; k < NM; k++)
						acc += floor16(longint'(jac[k][i]) * longint'(inv[k][j]));
					tm[i][j] = sat32_q(acc);
				end
		for (int i = 0; i < NS; i++)
			for (int j = 0; j < NM; j++) begin
				acc = 0;
				if (ok)
					for (int k = 0; k < NS; k++)
						acc += floor16(longint'(cov[i][k]) * longint'(tm[k][j]));
				g.gain_row = 3'(i);
				g.gain_col = 4'(j);
				g.gain_value = ok ? sat32_q(acc) : 32'sd0;
				g.last = (i == NS - 1 && j == NM - 1);
				g.singular = !ok;
				gain_expected.push_back(g);
			end
	endtask

	// Apply one accepted transaction to the model state
	task automatic apply_item(in_item_t it);
		case (it.mode)
			kgc_pkg::MODE_LOAD_H: begin
				if (it.row < NM && it.col < NS) jac[it.row][it.col] = it.value;
			end
			kgc_pkg::MODE_LOAD_P: begin
				if (it.row < NS && it.col < NS) cov[it.row][it.col] = it.value;
			end
			kgc_pkg::MODE_LOAD_R: begin
				if (it.row < NM && it.col < NM) noise[it.row][it.col] = it.value;
			end
			default: predict_gain();
		endcase
	endtask

	task automatic report(string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	function automatic bit sender_idles();
		if (accepted < total_items / 3) return ($urandom_range(0, 99) < 6);
		if (accepted < 2 * total_items / 3) return ($urandom_range(0, 99) < 79);
		return 1'b0;
	endfunction

	function automatic bit receiver_idles();
		if (accepted < total_items / 3) return ($urandom_range(0, 99) < 79);
		if (accepted < 2 * total_items / 3) return ($urandom_range(0, 99) < 6);
		return 1'b0;
	endfunction

	// Driver: present the head of the pending queue, hold it until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.data <= '0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				apply_item(pending_items.pop_front());
				accepted++;
			end
			if (!in_if.valid || in_if.ready) begin
				if (pending_items.size() > 0 && !sender_idles()) begin
					in_if.valid <= 1'b1;
					in_if.data <= pending_items[0];
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each gain transaction with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (gain_expected.size() == 0) begin
					report("gain entry with none expected");
				end else begin
					gain_item_t e;
					gain_item_t a;
					e = gain_expected.pop_front();
					a = out_if.data;
					if (a.gain_row !== e.gain_row)
						report($sformatf("gain_row %0d exp %0d", a.gain_row, e.gain_row));
					if (a.gain_col !== e.gain_col)
						report($sformatf("gain_col %0d exp %0d", a.gain_col, e.gain_col));
					if (a.gain_value !== e.gain_value)
						report($sformatf("gain_value %h exp %h at %0d,%0d",
							a.gain_value, e.gain_value, e.gain_row, e.gain_col));
					if (a.last !== e.last)
						report($sformatf("last %b exp %b", a.last, e.last));
					if (a.singular !== e.singular)
						report($sformatf("singular %b exp %b", a.singular, e.singular));
				end
			end
			out_if.ready <= !receiver_idles();
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic in_item_t mk(kgc_pkg::mode_t m, int r, int c, int v);
		in_item_t it;
		it.mode = m;
		it.row = 4'(r);
		it.col = 4'(c);
		it.value = v;
		return it;
	endfunction

	// Small signed value around zero, in Q16.16
	function automatic int small_val();
		return int'($urandom_range(0, 4 * 65536)) - 2 * 65536;
	endfunction

	// Load every entry of H, P and R; P and R get a dominant diagonal
	task automatic queue_full_load();
		for (int r = 0; r < NM; r++)
			for (int c = 0; c < NS; c++)
				pending_items.push_back(mk(kgc_pkg::MODE_LOAD_H, r, c, small_val()));
		for (int r = 0; r < NS; r++)
			for (int c = 0; c < NS; c++)
				pending_items.push_back(mk(kgc_pkg::MODE_LOAD_P, r, c,
					(r == c) ? 8 * 65536 + small_val() : small_val() / 4));
		for (int r = 0; r < NM; r++)
			for (int c = 0; c < NM; c++)
				pending_items.push_back(mk(kgc_pkg::MODE_LOAD_R, r, c,
					(r == c) ? 4 * 65536 + small_val() : small_val() / 8));
	endtask

	function automatic int rand_val();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return int'($urandom());
			default: return small_val();
		endcase
	endfunction

	initial begin
		int m, lim_r, lim_c, n;

		// Directed: full load, normal compute
		queue_full_load();
		pending_items.push_back(mk(kgc_pkg::MODE_COMPUTE, 0, 0, 0));
		// Out-of-range loads are dropped
		pending_items.push_back(mk(kgc_pkg::MODE_LOAD_H, 9, 0, 32'h7fffffff));
		pending_items.push_back(mk(kgc_pkg::MODE_LOAD_H, 0, 7, 32'h80000000));
		pending_items.push_back(mk(kgc_pkg::MODE_LOAD_P, 7, 7, -1));
		pending_items.push_back(mk(kgc_pkg::MODE_LOAD_R, 15, 15, 32'h7fffffff));
		pending_items.push_back(mk(kgc_pkg::MODE_LOAD_R, 9, 0, 12345));
		// Compute with junk in the unused fields
		pending_items.push_back(mk(kgc_pkg::MODE_COMPUTE, 15, 15, 32'hffffffff));
		// Zero pivot: clear one H row and its R row and column
		for (int c = 0; c < NS; c++)
			pending_items.push_back(mk(kgc_pkg::MODE_LOAD_H, 8, c, 0));
		for (int c = 0; c < NM; c++) begin
			pending_items.push_back(mk(kgc_pkg::MODE_LOAD_R, 8, c, 0));
			pending_items.push_back(mk(kgc_pkg::MODE_LOAD_R, c, 8, 0));
		end
		pending_items.push_back(mk(kgc_pkg::MODE_COMPUTE, 0, 0, 0));
		// Extremes that saturate the products
		pending_items.push_back(mk(kgc_pkg::MODE_LOAD_H, 8, 6, 32'h7fffffff));
		pending_items.push_back(mk(kgc_pkg::MODE_LOAD_H, 8, 0, 32'h80000000));
		pending_items.push_back(mk(kgc_pkg::MODE_LOAD_P, 6, 6, 32'h7fffffff));
		pending_items.push_back(mk(kgc_pkg::MODE_LOAD_R, 8, 8, 32'h80000000));
		pending_items.push_back(mk(kgc_pkg::MODE_COMPUTE, 0, 0, 0));

		// Random: bursts of loads ending in a compute, with some dropped loads
		n = 0;
		while (n < 20) begin
			for (int k = $urandom_range(5, 25); k > 0; k--) begin
				m = $urandom_range(0, 2);
				lim_r = (m == 1) ? NS : NM;
				lim_c = (m == 0 || m == 1) ? NS : NM;
				if ($urandom_range(0, 9) == 0)
					pending_items.push_back(mk(kgc_pkg::mode_t'(m), $urandom_range(0, 15),
						$urandom_range(0, 15), int'($urandom())));
				else
					pending_items.push_back(mk(kgc_pkg::mode_t'(m),
						$urandom_range(0, lim_r - 1), $urandom_range(0, lim_c - 1),
						rand_val()));
				n++;
			end
			pending_items.push_back(mk(kgc_pkg::MODE_COMPUTE, $urandom_range(0, 15),
				$urandom_range(0, 15), int'($urandom())));
			n++;
		end
		total_items = pending_items.size();

		// Reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Drain
		while (pending_items.size() > 0 || gain_expected.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
